/* src/okfc_pkg.sv */
// ----------------------------------------------------------------------------
// okfc_pkg: ordered key floor/ceiling shared definitions
// Item types, kind and status codes, sentinels and the slot that moves
// along the cell chain.
// ----------------------------------------------------------------------------
package okfc_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned KEY_W    = 32;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_CEIL   = 2'd1;
  localparam logic [1:0] KIND_FLOOR  = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_MISS = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  localparam logic signed [KEY_W-1:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [KEY_W-1:0] key;
  } in_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] value;
    logic [1:0]              status;
  } out_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [KEY_W-1:0] key;
    logic                    full;
    logic                    found;
    logic signed [KEY_W-1:0] best;
  } slot_t;

endpackage

/* src/okfc_cell.sv */
// ----------------------------------------------------------------------------
// okfc_cell: one storage cell of the key chain
// Holds one stored key and one item slot. Inserts write the key when their
// target index matches; queries fold the stored key into the running best.
// ----------------------------------------------------------------------------
module okfc_cell #(
  parameter int unsigned Index = 0,
  parameter int unsigned CntW  = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  okfc_pkg::slot_t     slot_i,
  input  logic [CntW-1:0]     cnt_i,
  output logic                valid_o,
  output okfc_pkg::slot_t     slot_o,
  output logic [CntW-1:0]     cnt_o
);

  logic                               valid_q;
  okfc_pkg::slot_t                    slot_q;
  logic [CntW-1:0]                    cnt_q;
  logic signed [okfc_pkg::KEY_W-1:0]  key_q;
  logic                               occupied;
  logic                               hit;
  logic                               wr_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      slot_q <= slot_i;
      cnt_q  <= cnt_i;
    end
  end

  assign wr_en = en_i && valid_q && (slot_q.kind == okfc_pkg::KIND_INSERT) &&
                 !slot_q.full && (cnt_q == CntW'(Index));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_q <= slot_q.key;
    end
  end

  assign occupied = CntW'(Index) < cnt_q;

  always_comb begin
    hit = 1'b0;
    case (slot_q.kind)
      okfc_pkg::KIND_CEIL:
        hit = occupied && (key_q >= slot_q.key) && (!slot_q.found || key_q < slot_q.best);
      okfc_pkg::KIND_FLOOR:
        hit = occupied && (key_q <= slot_q.key) && (!slot_q.found || key_q > slot_q.best);
      default:
        hit = 1'b0;
    endcase
  end

  always_comb begin
    slot_o = slot_q;
    if (hit) begin
      slot_o.found = 1'b1;
      slot_o.best  = key_q;
    end
  end

  assign valid_o = valid_q;
  assign cnt_o   = cnt_q;

endmodule

/* src/ordered_key_floor_ceiling.sv */
// ----------------------------------------------------------------------------
// ordered_key_floor_ceiling: bounded multiset with floor and ceiling queries
// Path: each item passes the cell registers and then the output register.
// Throughput: one item per cycle while the output is not stalled; each item
// walks the cell chain one cell per cycle; the chain has one cell per slot of Capacity.
// Reset: asynchronous, active low; the store starts empty and the chain
// holds no item. Stored keys are not cleared.
// ----------------------------------------------------------------------------
module ordered_key_floor_ceiling #(
  parameter int unsigned Capacity = okfc_pkg::CAPACITY
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  okfc_pkg::in_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output okfc_pkg::out_t out_data_o
);

  localparam int unsigned CntW = $clog2(Capacity + 1);

  logic                 en;
  logic                 accept;
  logic                 full;
  logic [CntW-1:0]      count_q, count_d;
  okfc_pkg::slot_t      entry_slot;
  logic                 valid_c [Capacity+1];
  okfc_pkg::slot_t      slot_c  [Capacity+1];
  logic [CntW-1:0]      cnt_c   [Capacity+1];
  logic                 out_valid_q;
  okfc_pkg::out_t       out_q, out_d;
  okfc_pkg::slot_t      last;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;
  assign accept     = in_valid_i && en;
  assign full       = count_q == CntW'(Capacity);

  always_comb begin
    count_d = count_q;
    if (accept && (in_data_i.kind == okfc_pkg::KIND_INSERT) && !full) begin
      count_d = count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_comb begin
    entry_slot.kind  = in_data_i.kind;
    entry_slot.key   = in_data_i.key;
    entry_slot.full  = full;
    entry_slot.found = 1'b0;
    entry_slot.best  = '0;
  end

  assign valid_c[0] = in_valid_i;
  assign slot_c[0]  = entry_slot;
  assign cnt_c[0]   = count_q;

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    okfc_cell #(
      .Index (i),
      .CntW  (CntW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_c[i]),
      .slot_i  (slot_c[i]),
      .cnt_i   (cnt_c[i]),
      .valid_o (valid_c[i+1]),
      .slot_o  (slot_c[i+1]),
      .cnt_o   (cnt_c[i+1])
    );
  end

  assign last = slot_c[Capacity];

  always_comb begin
    out_d.value  = '0;
    out_d.status = okfc_pkg::STATUS_OK;
    unique case (last.kind)
      okfc_pkg::KIND_INSERT: begin
        out_d.status = last.full ? okfc_pkg::STATUS_FULL : okfc_pkg::STATUS_OK;
      end
      okfc_pkg::KIND_CEIL: begin
        out_d.value  = last.found ? last.best : okfc_pkg::INT_MIN;
        out_d.status = last.found ? okfc_pkg::STATUS_OK : okfc_pkg::STATUS_MISS;
      end
      okfc_pkg::KIND_FLOOR: begin
        out_d.value  = last.found ? last.best : okfc_pkg::INT_MAX;
        out_d.status = last.found ? okfc_pkg::STATUS_OK : okfc_pkg::STATUS_MISS;
      end
      default: begin
        out_d.status = okfc_pkg::STATUS_MISS;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= valid_c[Capacity];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* src/okfc_checker.sv */
// ----------------------------------------------------------------------------
// okfc_checker: port-level checks for ordered_key_floor_ceiling
// Watches the handshakes and result codes on the top-level ports.
// ----------------------------------------------------------------------------
module okfc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input okfc_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input okfc_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result item changed");

  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow output backpressure");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status != 2'd3)
    else $error("undefined status code");

  a_miss_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == okfc_pkg::STATUS_MISS |->
      out_data_o.value == okfc_pkg::INT_MIN || out_data_o.value == okfc_pkg::INT_MAX ||
      out_data_o.value == '0)
    else $error("miss carries a value other than a sentinel");

  a_full_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == okfc_pkg::STATUS_FULL |-> out_data_o.value == '0)
    else $error("dropped insert carries a nonzero value");

endmodule

bind ordered_key_floor_ceiling okfc_checker u_okfc_checker (.*);
